// File: design/csx_pkg.sv
// ----------------------------------------------------------------------------
// CAN signal extract and scale: shared definitions
// Widths, pipeline depth, byte order and clamp codes, and the record that the
// field extractor hands to the arithmetic pipeline.
// ----------------------------------------------------------------------------
package csx_pkg;

   // Frame geometry.
   localparam int PAYLOAD_BYTES = 8;
   localparam int PAYLOAD_W     = 64;
   localparam int NBITS         = PAYLOAD_BYTES * 8;

   // Field widths.
   localparam int START_W  = 6;
   localparam int LEN_W    = 7;
   localparam int FACTOR_W = 32;
   localparam int VALUE_W  = 48;
   localparam int HALF_W   = 32;
   localparam int PROD_W   = PAYLOAD_W + FACTOR_W;
   localparam int SUM_W    = PROD_W + 2;

   // Register stages from input register to result register.
   localparam int STAGES = 7;

   // Byte order codes.
   localparam logic ORDER_INTEL    = 1'b0;
   localparam logic ORDER_MOTOROLA = 1'b1;

   typedef enum logic [1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_MAX  = 2'd1,
      CLAMP_MIN  = 2'd2
   } clamp_type;

   typedef struct packed {
      logic [PAYLOAD_W-1:0] raw;
      logic                 layout_error;
   } extract_type;

endpackage

// File: design/csx_req_if.sv
// ----------------------------------------------------------------------------
// CAN signal extract and scale: request channel
// One beat carries a payload and the descriptor of one signal to decode.
// ----------------------------------------------------------------------------
interface csx_req_if;
   import csx_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [PAYLOAD_W-1:0]        payload;
   logic [START_W-1:0]          start_bit;
   logic [LEN_W-1:0]            sig_length;
   logic                        byte_order;
   logic                        is_signed;
   logic signed [FACTOR_W-1:0]  factor;
   logic signed [VALUE_W-1:0]   offset_value;
   logic signed [VALUE_W-1:0]   min_value;
   logic signed [VALUE_W-1:0]   max_value;

   modport source (
      output valid, payload, start_bit, sig_length, byte_order, is_signed,
             factor, offset_value, min_value, max_value,
      input  ready
   );

   modport sink (
      input  valid, payload, start_bit, sig_length, byte_order, is_signed,
             factor, offset_value, min_value, max_value,
      output ready
   );

endinterface

// File: design/csx_rsp_if.sv
// ----------------------------------------------------------------------------
// CAN signal extract and scale: response channel
// One beat carries the raw field, the clamped physical value and status.
// ----------------------------------------------------------------------------
interface csx_rsp_if;
   import csx_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [PAYLOAD_W-1:0]      raw_value;
   logic signed [VALUE_W-1:0] phys_value;
   logic [1:0]                clamp_status;
   logic                      layout_error;

   modport source (
      output valid, raw_value, phys_value, clamp_status, layout_error,
      input  ready
   );

   modport sink (
      input  valid, raw_value, phys_value, clamp_status, layout_error,
      output ready
   );

endinterface

// File: design/csx_extract.sv
// ----------------------------------------------------------------------------
// CAN signal extract and scale: field extractor
// Pulls one DBC signal out of the payload in Intel or Motorola bit numbering
// and flags a zero or oversized length or a layout that leaves the payload.
// ----------------------------------------------------------------------------
module csx_extract (
   input  logic [csx_pkg::PAYLOAD_W-1:0] payload,
   input  logic [csx_pkg::START_W-1:0]   start_bit,
   input  logic [csx_pkg::LEN_W-1:0]     sig_length,
   input  logic                          byte_order,
   output csx_pkg::extract_type          result
);
   import csx_pkg::*;

   logic [PAYLOAD_W-1:0] len_mask;
   logic [PAYLOAD_W-1:0] intel_raw;
   logic [PAYLOAD_W-1:0] swapped;
   logic [PAYLOAD_W-1:0] shifted;
   logic [PAYLOAD_W-1:0] reversed;
   logic [PAYLOAD_W-1:0] moto_raw;
   logic [START_W-1:0]   moto_msb;
   logic [LEN_W:0]       intel_end;
   logic [LEN_W:0]       moto_end;
   logic                 len_bad;
   logic                 bad;

   // A length of 64 shifts every one out, which leaves the mask all ones.
   assign len_mask = ~({PAYLOAD_W{1'b1}} << sig_length);

   // Intel: the start bit is the LSB and bits rise through the frame.
   assign intel_raw = (payload >> start_bit) & len_mask;

   // Motorola: reversing the bits of each byte gives a linear MSB-first
   // order in which the signal is one contiguous run starting at moto_msb.
   assign moto_msb = start_bit ^ START_W'(7);

   always_comb begin
      for (int k = 0; k < PAYLOAD_W; k++) begin
         swapped[k] = payload[(k / 8) * 8 + 7 - (k % 8)];
      end
   end

   assign shifted = swapped >> moto_msb;

   always_comb begin
      for (int k = 0; k < PAYLOAD_W; k++) begin
         reversed[k] = shifted[PAYLOAD_W-1-k];
      end
   end

   assign moto_raw = reversed >> (LEN_W'(PAYLOAD_W) - sig_length);

   // Layout check against the last payload bit.
   assign intel_end = {2'b00, start_bit} + {1'b0, sig_length};
   assign moto_end  = {2'b00, moto_msb} + {1'b0, sig_length};
   assign len_bad   = (sig_length == '0) || (sig_length > LEN_W'(PAYLOAD_W));

   always_comb begin
      if (byte_order == ORDER_MOTOROLA) begin
         bad = len_bad || (moto_end > (LEN_W+1)'(NBITS));
      end else begin
         bad = len_bad || (intel_end > (LEN_W+1)'(NBITS));
      end
   end

   // A bad layout yields a zero raw field.
   always_comb begin
      result.layout_error = bad;
      if (bad) begin
         result.raw = '0;
      end else if (byte_order == ORDER_MOTOROLA) begin
         result.raw = moto_raw;
      end else begin
         result.raw = intel_raw;
      end
   end

endmodule

// File: design/can_signal_extract_scale.sv
// ----------------------------------------------------------------------------
// CAN signal extract and scale
// Decodes one DBC signal per beat: extraction, sign handling, scaling,
// offset and clamping in a seven-stage pipeline.
// ----------------------------------------------------------------------------
// The block takes one request beat per cycle while req_ch.ready is high and
// returns one response beat per request, in order. The depth comes from
// the 64 by 32 bit scaling multiply,
// done as two 32 by 32 bit partial products, followed by the 96 bit combine,
// the 98 bit offset add and the limit compare, each in its own stage. Stages
// that hold no beat keep accepting while a finished response waits, so the
// request side stalls only when all seven stages are full. A layout error
// returns zero for the raw field, the physical value and the clamp status.
module can_signal_extract_scale (
   input logic       clock,
   input logic       reset,
   csx_req_if.sink   req_ch,
   csx_rsp_if.source rsp_ch
);
   import csx_pkg::*;

   // Fields that ride along the arithmetic stages unchanged.
   typedef struct packed {
      logic [PAYLOAD_W-1:0]      raw;
      logic                      layout_error;
      logic signed [VALUE_W-1:0] offset_value;
      logic signed [VALUE_W-1:0] min_value;
      logic signed [VALUE_W-1:0] max_value;
   } carry_type;

   // Pipeline occupancy and load enables.
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] en;

   // Stage 1: input register.
   logic [PAYLOAD_W-1:0]      payload1_ff;
   logic [START_W-1:0]        start1_ff;
   logic [LEN_W-1:0]          len1_ff;
   logic                      order1_ff;
   logic                      sgn1_ff;
   logic [FACTOR_W-1:0]       factor1_ff;
   logic signed [VALUE_W-1:0] offset1_ff;
   logic signed [VALUE_W-1:0] min1_ff;
   logic signed [VALUE_W-1:0] max1_ff;

   // Stage 2: extracted field.
   extract_type               ext_in;
   carry_type                 carry2_ff;
   logic [LEN_W-1:0]          len2_ff;
   logic                      sgn2_ff;
   logic [FACTOR_W-1:0]       factor2_ff;

   // Stage 3: magnitudes and result sign.
   logic [PAYLOAD_W-1:0]      mask3;
   logic [PAYLOAD_W-1:0]      pattern3;
   logic                      raw_neg3;
   logic                      fac_neg3;
   logic [PAYLOAD_W-1:0]      mag_in;
   logic [FACTOR_W-1:0]       fmag_in;
   carry_type                 carry3_ff;
   logic [PAYLOAD_W-1:0]      mag3_ff;
   logic [FACTOR_W-1:0]       fmag3_ff;
   logic                      neg3_ff;

   // Stage 4: partial products.
   logic [PAYLOAD_W-1:0]      p0_in;
   logic [PAYLOAD_W-1:0]      p1_in;
   carry_type                 carry4_ff;
   logic [PAYLOAD_W-1:0]      p0_4_ff;
   logic [PAYLOAD_W-1:0]      p1_4_ff;
   logic                      neg4_ff;

   // Stage 5: full product magnitude.
   logic [PROD_W-1:0]         prod_in;
   carry_type                 carry5_ff;
   logic [PROD_W-1:0]         prod5_ff;
   logic                      neg5_ff;

   // Stage 6: signed value with offset.
   logic [SUM_W-1:0]          ext6;
   logic [SUM_W-1:0]          flip6;
   logic [SUM_W-1:0]          off6;
   logic signed [SUM_W-1:0]   val_in;
   carry_type                 carry6_ff;
   logic signed [SUM_W-1:0]   val6_ff;

   // Stage 7: result register.
   logic signed [SUM_W-1:0]   hi_ext;
   logic signed [SUM_W-1:0]   lo_ext;
   logic signed [VALUE_W-1:0] phys_in;
   clamp_type                 status_in;
   logic [PAYLOAD_W-1:0]      raw_out_ff;
   logic signed [VALUE_W-1:0] phys_out_ff;
   clamp_type                 status_out_ff;
   logic                      err_out_ff;

   // A stage loads when it is empty or its beat moves on this cycle.
   always_comb begin
      en[STAGES-1] = !vld_ff[STAGES-1] || rsp_ch.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign vld_in = {vld_ff[STAGES-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (en & vld_in) | (~en & vld_ff);
      end
   end

   assign req_ch.ready = en[0];

   // Stage 1: capture the request beat.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         payload1_ff <= req_ch.payload;
         start1_ff   <= req_ch.start_bit;
         len1_ff     <= req_ch.sig_length;
         order1_ff   <= req_ch.byte_order;
         sgn1_ff     <= req_ch.is_signed;
         factor1_ff  <= req_ch.factor;
         offset1_ff  <= req_ch.offset_value;
         min1_ff     <= req_ch.min_value;
         max1_ff     <= req_ch.max_value;
      end
   end

   // Stage 2: field extraction.
   csx_extract u_extract (
      .payload    (payload1_ff),
      .start_bit  (start1_ff),
      .sig_length (len1_ff),
      .byte_order (order1_ff),
      .result     (ext_in)
   );

   always_ff @(posedge clock) begin
      if (en[1]) begin
         carry2_ff.raw          <= ext_in.raw;
         carry2_ff.layout_error <= ext_in.layout_error;
         carry2_ff.offset_value <= offset1_ff;
         carry2_ff.min_value    <= min1_ff;
         carry2_ff.max_value    <= max1_ff;
         len2_ff                <= len1_ff;
         sgn2_ff                <= sgn1_ff;
         factor2_ff             <= factor1_ff;
      end
   end

   // Stage 3: sign-extend a signed field longer than one bit and take
   // magnitudes of the field and the factor.
   assign mask3    = ~({PAYLOAD_W{1'b1}} << len2_ff);
   assign pattern3 = carry2_ff.raw | ~mask3;
   assign raw_neg3 = sgn2_ff && (len2_ff > LEN_W'(1)) &&
                     carry2_ff.raw[START_W'(len2_ff - LEN_W'(1))];
   assign fac_neg3 = factor2_ff[FACTOR_W-1];
   assign mag_in   = raw_neg3 ? (~pattern3 + PAYLOAD_W'(1)) : carry2_ff.raw;
   assign fmag_in  = fac_neg3 ? (~factor2_ff + FACTOR_W'(1)) : factor2_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         carry3_ff <= carry2_ff;
         mag3_ff   <= mag_in;
         fmag3_ff  <= fmag_in;
         neg3_ff   <= raw_neg3 ^ fac_neg3;
      end
   end

   // Stage 4: two 32 by 32 bit partial products.
   assign p0_in = mag3_ff[HALF_W-1:0] * fmag3_ff;
   assign p1_in = mag3_ff[PAYLOAD_W-1:HALF_W] * fmag3_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         carry4_ff <= carry3_ff;
         p0_4_ff   <= p0_in;
         p1_4_ff   <= p1_in;
         neg4_ff   <= neg3_ff;
      end
   end

   // Stage 5: combine the partial products into the unsigned product.
   assign prod_in = {p1_4_ff + {{HALF_W{1'b0}}, p0_4_ff[PAYLOAD_W-1:HALF_W]},
                     p0_4_ff[HALF_W-1:0]};

   always_ff @(posedge clock) begin
      if (en[4]) begin
         carry5_ff <= carry4_ff;
         prod5_ff  <= prod_in;
         neg5_ff   <= neg4_ff;
      end
   end

   // Stage 6: apply the sign as invert plus carry-in, and add the offset.
   assign ext6  = {2'b00, prod5_ff};
   assign flip6 = neg5_ff ? ~ext6 : ext6;
   assign off6  = {{(SUM_W-VALUE_W){carry5_ff.offset_value[VALUE_W-1]}},
                   carry5_ff.offset_value};
   assign val_in = flip6 + off6 + {{(SUM_W-1){1'b0}}, neg5_ff};

   always_ff @(posedge clock) begin
      if (en[5]) begin
         carry6_ff <= carry5_ff;
         val6_ff   <= val_in;
      end
   end

   // Stage 7: clamp, testing the upper limit first.
   assign hi_ext = {{(SUM_W-VALUE_W){carry6_ff.max_value[VALUE_W-1]}},
                    carry6_ff.max_value};
   assign lo_ext = {{(SUM_W-VALUE_W){carry6_ff.min_value[VALUE_W-1]}},
                    carry6_ff.min_value};

   always_comb begin
      if (carry6_ff.layout_error) begin
         phys_in   = '0;
         status_in = CLAMP_NONE;
      end else if (val6_ff > hi_ext) begin
         phys_in   = carry6_ff.max_value;
         status_in = CLAMP_MAX;
      end else if (val6_ff < lo_ext) begin
         phys_in   = carry6_ff.min_value;
         status_in = CLAMP_MIN;
      end else begin
         phys_in   = val6_ff[VALUE_W-1:0];
         status_in = CLAMP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         raw_out_ff    <= carry6_ff.raw;
         phys_out_ff   <= phys_in;
         status_out_ff <= status_in;
         err_out_ff    <= carry6_ff.layout_error;
      end
   end

   assign rsp_ch.valid        = vld_ff[STAGES-1];
   assign rsp_ch.raw_value    = raw_out_ff;
   assign rsp_ch.phys_value   = phys_out_ff;
   assign rsp_ch.clamp_status = status_out_ff;
   assign rsp_ch.layout_error = err_out_ff;

   // A beat with a layout error carries nothing but the flag.
   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.layout_error |->
         rsp_ch.raw_value == '0 && rsp_ch.phys_value == '0 &&
         rsp_ch.clamp_status == CLAMP_NONE)
      else $error("layout error beat carries nonzero result fields");

   // An accepted request beat always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> vld_ff[0])
      else $error("accepted request beat lost at the input register");

   // The request side stalls only when every stage holds a beat.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> &vld_ff)
      else $error("request stalled while the pipeline has a free stage");

endmodule
